// ----- design/pwm_encoder_multiturn_decoder_defines.svh -----
// assertion macros for the pwm encoder multi-turn decoder
// used by the top level only; no other dependencies
`ifndef PWM_ENCODER_MULTITURN_DECODER_DEFINES_SVH
`define PWM_ENCODER_MULTITURN_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
`define PEMD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PEMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PEMD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PEMD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/pemd_pkg.sv -----
// shared types and constants for the pwm encoder multi-turn decoder
// no dependencies
`default_nettype none
package pemd_pkg;
  localparam int RES_BITS = 12;
  localparam int ANG_W    = RES_BITS + 8;
  localparam int CFG_DW   = 24;
  localparam int CFG_IW   = 3;
  localparam int POS_W    = 48;

  localparam logic signed [17:0] EMA_ALPHA = 18'sd6554;
  localparam logic [31:0] CNT_TOP = 32'(((1 << RES_BITS) - 1) << 8);
  localparam logic signed [ANG_W+1:0] HALF_S = (ANG_W+2)'(1 << (ANG_W - 1));
  localparam logic signed [ANG_W+1:0] TURN_S = (ANG_W+2)'(1 << ANG_W);

  typedef enum logic [CFG_IW-1:0] {
    CFG_SCALE  = 3'd0,
    CFG_START  = 3'd1,
    CFG_MIN    = 3'd2,
    CFG_MAX    = 3'd3,
    CFG_DIR    = 3'd4,
    CFG_OFFSET = 3'd5,
    CFG_GEAR   = 3'd6,
    CFG_FILTER = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [23:0] scale;
    logic [9:0]  start;
    logic [15:0] min_ticks;
    logic [15:0] max_ticks;
    logic        dir_neg;
    logic [11:0] offset;
    logic [16:0] gear;
    logic [1:0]  filter;
  } cfg_t;

  // one queue entry: sanity verdict and the filtered width
  typedef struct packed {
    logic        ok;
    logic [15:0] width;
  } q_item_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;
endpackage
`default_nettype wire

// ----- design/pemd_if.sv -----
// channel interfaces for the pwm encoder multi-turn decoder
// no dependencies
`default_nettype none
interface pemd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] pulse_ticks;
  logic        new_sample;
  logic        ema_alpha_unused_guard;
  modport source (output valid, pulse_ticks, new_sample, ema_alpha_unused_guard, input ready);
  modport sink (input valid, pulse_ticks, new_sample, ema_alpha_unused_guard, output ready);
endinterface

interface pemd_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] joint_position;
  logic        updated;
  modport source (output valid, joint_position, updated, input ready);
  modport sink (input valid, joint_position, updated, output ready);
endinterface
`default_nettype wire

// ----- design/pemd_front.sv -----
// front end: sanity check and median-of-3 history
// depends on pemd_pkg
`default_nettype none
module pemd_front
  import pemd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire logic        accept,
  input  wire logic [15:0] pulse,
  input  wire logic        fresh,
  output q_item_t          item
);
  logic [15:0] hist_r [3];
  logic [15:0] hist_nxt [3];
  logic [1:0]  slot_r, slot_nxt;
  logic        full_r, full_nxt;
  logic        ok;
  logic [1:0]  slot;

  function automatic logic [15:0] med3(input logic [15:0] a, b, c);
    logic [15:0] x, y, z, t;
    x = a; y = b; z = c;
    if (x > y) begin t = x; x = y; y = t; end
    if (y > z) begin y = z; end
    if (x > y) begin y = x; end
    return y;
  endfunction

  assign ok = (pulse != 16'd0) && (pulse >= cfg.min_ticks) && (pulse <= cfg.max_ticks);
  assign slot = (slot_r == 2'd3) ? 2'd0 : slot_r;

  // history update for a fresh, good width with the median on
  always_comb begin
    hist_nxt = hist_r;
    slot_nxt = slot_r;
    full_nxt = full_r;
    if (ok && cfg.filter[0] && fresh) begin
      hist_nxt[slot] = pulse;
      if (slot == 2'd2) full_nxt = 1'b1;
      slot_nxt = (slot == 2'd2) ? 2'd0 : slot + 2'd1;
    end
  end

  // width handed to the back end
  always_comb begin
    item.ok    = ok;
    item.width = pulse;
    if (cfg.filter[0] && full_nxt) begin
      item.width = med3(hist_nxt[0], hist_nxt[1], hist_nxt[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '{16'd0, 16'd0, 16'd0};
      slot_r <= 2'd0;
      full_r <= 1'b0;
    end else if (accept) begin
      hist_r <= hist_nxt;
      slot_r <= slot_nxt;
      full_r <= full_nxt;
    end
  end
endmodule
`default_nettype wire

// ----- design/pemd_queue.sv -----
// two-entry queue between front and back ends
// depends on pemd_pkg
`default_nettype none
module pemd_queue
  import pemd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire q_item_t push_item,
  input  wire logic    pop,
  output q_item_t      head,
  output q_stat_t      stat
);
  q_item_t    mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign head       = mem_r[rp_r];
  assign stat.valid = (cnt_r != 2'd0);
  assign stat.full  = (cnt_r == 2'd2);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_nxt;
    end
  end
endmodule
`default_nettype wire

// ----- design/pemd_back.sv -----
// back end: counts, turn tracking, gear scaling, smoothing, output register
// depends on pemd_pkg
`default_nettype none
module pemd_back
  import pemd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire q_item_t     head,
  input  wire q_stat_t     qstat,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [POS_W-1:0] out_pos,
  output logic             out_upd
);
  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_CLAMP = 9'b000000010,
    ST_ANGLE = 9'b000000100,
    ST_PLO   = 9'b000001000,
    ST_PHI   = 9'b000010000,
    ST_SUM   = 9'b000100000,
    ST_EMA   = 9'b001000000,
    ST_EMA2  = 9'b010000000,
    ST_FIN   = 9'b100000000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [39:0]              prod_r;
  logic [ANG_W-1:0]         cnt_r, prev_r;
  logic                     seen_r, started_r, upd_r;
  logic [POS_W-1:0]         acc_r, s_r, held_r, raw_r;
  logic [40:0]              plo_r;
  logic signed [41:0]       phi_r;
  logic signed [66:0]       emap_r;
  logic                     ovalid_r, oupd_r;
  logic [POS_W-1:0]         opos_r;

  logic [31:0]              cnt_hi, start_q8, cnt_d;
  logic [ANG_W-1:0]         cnt_nxt, ang_dir, ang;
  logic signed [ANG_W+1:0]  dstep;
  logic [65:0]              full;
  logic [POS_W-1:0]         raw_nxt;
  logic [POS_W:0]           ediff;
  logic                     fin_go;

  assign pop       = (state_r == ST_IDLE) && qstat.valid;
  assign fin_go    = (state_r == ST_FIN) && (!ovalid_r || out_ready);
  assign out_valid = ovalid_r;
  assign out_pos   = opos_r;
  assign out_upd   = oupd_r;

  // subtract the start clocks and clamp to one turn of counts
  always_comb begin
    cnt_hi   = prod_r[39:8];
    start_q8 = {14'd0, cfg.start, 8'd0};
    cnt_d    = cnt_hi - start_q8;
    if (cnt_hi <= start_q8) cnt_nxt = '0;
    else if (cnt_d > CNT_TOP) cnt_nxt = CNT_TOP[ANG_W-1:0];
    else cnt_nxt = cnt_d[ANG_W-1:0];
  end

  // direction, offset and wrapped step
  always_comb begin
    ang_dir = cfg.dir_neg ? (ANG_W'(0) - cnt_r) : cnt_r;
    ang     = ang_dir + ANG_W'({cfg.offset, 8'd0});
    dstep   = $signed({2'b00, ang}) - $signed({2'b00, prev_r});
    if (dstep > HALF_S) dstep = dstep - TURN_S;
    if (dstep <= -HALF_S) dstep = dstep + TURN_S;
  end

  // combine partial products, floor shift and saturate
  always_comb begin
    full = {phi_r, 24'd0} + {25'd0, plo_r};
    if ((&full[65:55]) || !(|full[65:55])) raw_nxt = full[55:8];
    else if (full[65]) raw_nxt = {1'b1, {(POS_W-1){1'b0}}};
    else raw_nxt = {1'b0, {(POS_W-1){1'b1}}};
    ediff = {raw_r[POS_W-1], raw_r} - {s_r[POS_W-1], s_r};
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (qstat.valid) state_nxt = head.ok ? ST_CLAMP : ST_FIN;
      ST_CLAMP: state_nxt = ST_ANGLE;
      ST_ANGLE: state_nxt = ST_PLO;
      ST_PLO:   state_nxt = ST_PHI;
      ST_PHI:   state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_EMA;
      ST_EMA:   state_nxt = (cfg.filter[1] && started_r) ? ST_EMA2 : ST_FIN;
      ST_EMA2:  state_nxt = ST_FIN;
      ST_FIN:   if (fin_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    if (pop) prod_r <= 40'(head.width * cfg.scale);
    if (state_r == ST_CLAMP) cnt_r <= cnt_nxt;
    if (state_r == ST_PLO) plo_r <= acc_r[23:0] * cfg.gear;
    if (state_r == ST_PHI) phi_r <= $signed(acc_r[47:24]) * $signed({1'b0, cfg.gear});
    if (state_r == ST_SUM) raw_r <= raw_nxt;
    if (state_r == ST_EMA) emap_r <= $signed(ediff) * EMA_ALPHA;
    if (fin_go) begin
      opos_r <= held_r;
      oupd_r <= upd_r;
    end
  end

  // tracking state and control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      prev_r    <= '0;
      seen_r    <= 1'b0;
      acc_r     <= '0;
      s_r       <= '0;
      started_r <= 1'b0;
      held_r    <= '0;
      upd_r     <= 1'b0;
      ovalid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pop) upd_r <= head.ok;
      if (state_r == ST_ANGLE) begin
        prev_r <= ang;
        seen_r <= 1'b1;
        if (!seen_r) acc_r <= {{(POS_W-ANG_W){1'b0}}, ang};
        else acc_r <= acc_r + {{(POS_W-ANG_W-2){dstep[ANG_W+1]}}, dstep};
      end
      if (state_r == ST_EMA) begin
        if (!cfg.filter[1]) held_r <= raw_r;
        else if (!started_r) begin
          s_r       <= raw_r;
          held_r    <= raw_r;
          started_r <= 1'b1;
        end
      end
      if (state_r == ST_EMA2) begin
        s_r    <= s_r + emap_r[63:16];
        held_r <= s_r + emap_r[63:16];
      end
      if (fin_go) ovalid_r <= 1'b1;
      else if (out_ready) ovalid_r <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ----- design/pwm_encoder_multiturn_decoder.sv -----
// top level of the pwm encoder multi-turn decoder: config registers and wiring
// depends on pemd_pkg, pemd_if, pemd_front, pemd_queue, pemd_back, defines header
//
// channel  | dir | payload
// in_bus   | in  | pulse_ticks[16], new_sample, ema_alpha_unused_guard
// out_bus  | out | joint_position[48] signed, updated
// cfg_*    | in  | cfg_index[3], cfg_data[24], write on cfg_we
//
// a good width runs from queue pop through the clamp, angle, gear-low, gear-high,
// sum, smoothing and, if smoothing runs, second smoothing states to finish;
// a rejected width goes straight to finish. the front takes a beat per cycle while
// the two-entry queue has room. synchronous active-low reset clears all tracking
// state; the output register holds a result until out_bus.ready takes it.
`include "pwm_encoder_multiturn_decoder_defines.svh"
`default_nettype none
module pwm_encoder_multiturn_decoder
  import pemd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  pemd_in_if.sink                in_bus,
  pemd_out_if.source             out_bus,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_data
);
  cfg_t    cfg_r;
  q_item_t fitem, head;
  q_stat_t qstat;
  logic    in_acc, pop;

  assign in_bus.ready = !qstat.full;
  assign in_acc       = in_bus.valid && in_bus.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale     <= 24'd65536;
      cfg_r.start     <= 10'd16;
      cfg_r.min_ticks <= 16'd28;
      cfg_r.max_ticks <= 16'd20625;
      cfg_r.dir_neg   <= 1'b0;
      cfg_r.offset    <= 12'd0;
      cfg_r.gear      <= 17'd65536;
      cfg_r.filter    <= 2'd3;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SCALE:  cfg_r.scale     <= cfg_data;
        CFG_START:  cfg_r.start     <= cfg_data[9:0];
        CFG_MIN:    cfg_r.min_ticks <= cfg_data[15:0];
        CFG_MAX:    cfg_r.max_ticks <= cfg_data[15:0];
        CFG_DIR:    cfg_r.dir_neg   <= cfg_data[0];
        CFG_OFFSET: cfg_r.offset    <= cfg_data[11:0];
        CFG_GEAR:   cfg_r.gear      <= cfg_data[16:0];
        CFG_FILTER: cfg_r.filter    <= cfg_data[1:0];
        default:    cfg_r.filter    <= cfg_r.filter;
      endcase
    end
  end

  pemd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .accept (in_acc),
    .pulse  (in_bus.pulse_ticks),
    .fresh  (in_bus.new_sample),
    .item   (fitem)
  );

  pemd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc),
    .push_item (fitem),
    .pop       (pop),
    .head      (head),
    .stat      (qstat)
  );

  pemd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .out_pos   (out_bus.joint_position),
    .out_upd   (out_bus.updated)
  );

  // queue bookkeeping checks
  `PEMD_ASSERT_SAME(a_no_push_full, clk, rst_n, in_acc, !qstat.full)
  `PEMD_ASSERT_SAME(a_pop_nonempty, clk, rst_n, pop, qstat.valid)
  `PEMD_ASSERT_NEXT(a_push_lands, clk, rst_n, in_acc, qstat.valid)
endmodule
`default_nettype wire
